// ===== hw/rtl/ssw_pkg.sv =====
package ssw_pkg;

  localparam int DIMS        = 4;
  localparam int CAPACITY    = 32;
  localparam int ATTR_BITS   = 16;
  localparam int INPUT_ATTRS = 4;

  localparam int ID_W       = 31;
  localparam int DIST_W     = 16;
  localparam int FIELD_W    = 16;
  localparam int KW_W       = 32;
  localparam int MASK_W     = 4;
  localparam int STAT_W     = 2;
  localparam int REM_W      = 6;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] REG_SUBSPACE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_KEYWORD  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DIST     = 2'd2;

  localparam logic [STAT_W-1:0] STAT_INS  = 2'd0;
  localparam logic [STAT_W-1:0] STAT_DOM  = 2'd1;
  localparam logic [STAT_W-1:0] STAT_FILT = 2'd2;
  localparam logic [STAT_W-1:0] STAT_FULL = 2'd3;

  typedef logic [DIMS-1:0][ATTR_BITS-1:0] attr_vec_t;

  typedef struct packed {
    logic seen_free;
    logic seen_pend;
  } ssw_chain_t;

  typedef struct packed {
    attr_vec_t       attrs;
    logic [DIMS-1:0] mask;
    logic [ID_W-1:0] ident;
    logic            apply;
    logic            rd_load;
    logic            rd_step;
  } ssw_bcast_t;

  typedef struct packed {
    logic            dom_by;
    logic            kill;
    logic            pend;
    logic            sel;
    logic [ID_W-1:0] id_sel;
  } ssw_cell_st_t;

  // a dominates b: a <= b on every masked dimension and not equal on all of them
  function automatic logic dominates(attr_vec_t a, attr_vec_t b, logic [DIMS-1:0] mask);
    logic all_le;
    logic all_eq;
    all_le = 1'b1;
    all_eq = 1'b1;
    for (int d = 0; d < DIMS; d++) begin
      if (mask[d]) begin
        if (a[d] > b[d]) all_le = 1'b0;
        if (a[d] != b[d]) all_eq = 1'b0;
      end
    end
    return all_le && !all_eq;
  endfunction

endpackage

// ===== hw/rtl/ssw_if.sv =====
interface ssw_in_if;
  logic                         valid;
  logic                         ready;
  logic                         mode;
  logic [ssw_pkg::ID_W-1:0]     poi_id;
  logic [ssw_pkg::DIST_W-1:0]   distance;
  logic [ssw_pkg::FIELD_W-1:0]  attr_zero;
  logic [ssw_pkg::FIELD_W-1:0]  attr_one;
  logic [ssw_pkg::FIELD_W-1:0]  attr_two;
  logic [ssw_pkg::FIELD_W-1:0]  attr_three;
  logic [ssw_pkg::KW_W-1:0]     poi_keywords;

  modport source (
    output valid, mode, poi_id, distance, attr_zero, attr_one, attr_two, attr_three,
           poi_keywords,
    input  ready
  );
  modport sink (
    input  valid, mode, poi_id, distance, attr_zero, attr_one, attr_two, attr_three,
           poi_keywords,
    output ready
  );
endinterface

interface ssw_out_if;
  logic                         valid;
  logic                         ready;
  logic [ssw_pkg::STAT_W-1:0]   status;
  logic [ssw_pkg::REM_W-1:0]    removed_count;
  logic [ssw_pkg::ID_W-1:0]     out_poi_id;
  logic                         entry_valid;
  logic                         last;

  modport source (
    output valid, status, removed_count, out_poi_id, entry_valid, last,
    input  ready
  );
  modport sink (
    input  valid, status, removed_count, out_poi_id, entry_valid, last,
    output ready
  );
endinterface

// ===== hw/rtl/ssw_cell.sv =====
module ssw_cell (
  input  logic                  clk,
  input  logic                  rst_n,
  input  ssw_pkg::ssw_bcast_t   bcast,
  input  ssw_pkg::ssw_chain_t   chain_in,
  output ssw_pkg::ssw_chain_t   chain_out,
  output ssw_pkg::ssw_cell_st_t st
);

  logic                     valid_r;
  logic                     pend_r;
  logic                     dom_by_r;
  logic                     kill_r;
  ssw_pkg::attr_vec_t       attrs_r;
  logic [ssw_pkg::ID_W-1:0] ident_r;

  logic free;
  logic first_free;
  logic sel;

  always_comb begin
    free                = !valid_r || kill_r;
    first_free          = free && !chain_in.seen_free;
    sel                 = pend_r && !chain_in.seen_pend;
    chain_out.seen_free = chain_in.seen_free || free;
    chain_out.seen_pend = chain_in.seen_pend || pend_r;
    st.dom_by           = dom_by_r;
    st.kill             = kill_r;
    st.pend             = pend_r;
    st.sel              = sel;
    st.id_sel           = sel ? ident_r : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r  <= 1'b0;
      pend_r   <= 1'b0;
      dom_by_r <= 1'b0;
      kill_r   <= 1'b0;
    end else begin
      dom_by_r <= valid_r && ssw_pkg::dominates(attrs_r, bcast.attrs, bcast.mask);
      kill_r   <= valid_r && ssw_pkg::dominates(bcast.attrs, attrs_r, bcast.mask);
      if (bcast.apply) begin
        if (first_free) begin
          valid_r <= 1'b1;
        end else if (kill_r) begin
          valid_r <= 1'b0;
        end
      end
      if (bcast.rd_load) begin
        pend_r <= valid_r;
      end else if (bcast.rd_step && sel) begin
        pend_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (bcast.apply && first_free) begin
      attrs_r <= bcast.attrs;
      ident_r <= bcast.ident;
    end
  end

endmodule

// ===== hw/rtl/subspace_skyline_window_unit.sv =====
// Offer: taken in idle, then compare and decide; the result is registered from decide once the
//   output is free, and the next offer is taken back in idle. Readout: one identifier per cycle
//   while the output is taken; an empty window gives one transaction with no entry.
// Compare against all stored points happens in parallel in the cell row; insert slot and
//   readout order follow the lowest-index chain through the cells.
// Reset (synchronous, rst_n low): window empty, control and configuration registers to their defaults, no output.
module subspace_skyline_window_unit (
  input  logic                           clk,
  input  logic                           rst_n,
  ssw_in_if.sink                         in_ch,
  ssw_out_if.source                      out_ch,
  input  logic                           cfg_we,
  input  logic [ssw_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  logic [ssw_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_CMP  = 3'd1;
  localparam logic [2:0] ST_DEC  = 3'd2;
  localparam logic [2:0] ST_RD   = 3'd3;

  logic [2:0] state_r, state_nxt;

  logic [ssw_pkg::MASK_W-1:0] sub_mask_r;
  logic [ssw_pkg::KW_W-1:0]   kw_mask_r;
  logic [ssw_pkg::DIST_W-1:0] dist_lim_r;

  ssw_pkg::attr_vec_t         cand_attrs_r, cand_attrs_nxt;
  logic [ssw_pkg::ID_W-1:0]   cand_id_r;
  logic                       pass_r;

  logic                         out_valid_r;
  logic [ssw_pkg::STAT_W-1:0]   out_status_r, out_status_nxt;
  logic [ssw_pkg::REM_W-1:0]    out_removed_r, out_removed_nxt;
  logic [ssw_pkg::ID_W-1:0]     out_id_r, out_id_nxt;
  logic                         out_ev_r, out_ev_nxt;
  logic                         out_last_r, out_last_nxt;
  logic                         emit;

  ssw_pkg::ssw_bcast_t   bcast;
  ssw_pkg::ssw_chain_t   chain [ssw_pkg::CAPACITY+1];
  ssw_pkg::ssw_cell_st_t cst   [ssw_pkg::CAPACITY];

  logic [ssw_pkg::CAPACITY-1:0] dom_vec, kill_vec, pend_vec, sel_vec;
  logic [ssw_pkg::ID_W-1:0]     rd_id;
  logic                         any_dom, any_free, any_pend, accept, out_free, do_insert;
  logic [ssw_pkg::FIELD_W-1:0]  in_attr [ssw_pkg::INPUT_ATTRS];

  assign accept   = in_ch.valid && in_ch.ready;
  assign out_free = !out_valid_r || out_ch.ready;

  assign in_ch.ready          = (state_r == ST_IDLE);
  assign out_ch.valid         = out_valid_r;
  assign out_ch.status        = out_status_r;
  assign out_ch.removed_count = out_removed_r;
  assign out_ch.out_poi_id    = out_id_r;
  assign out_ch.entry_valid   = out_ev_r;
  assign out_ch.last          = out_last_r;

  assign in_attr[0] = in_ch.attr_zero;
  assign in_attr[1] = in_ch.attr_one;
  assign in_attr[2] = in_ch.attr_two;
  assign in_attr[3] = in_ch.attr_three;

  always_comb begin
    for (int d = 0; d < ssw_pkg::DIMS; d++) begin
      if (d < ssw_pkg::INPUT_ATTRS) begin
        cand_attrs_nxt[d] = ssw_pkg::ATTR_BITS'(in_attr[d]);
      end else begin
        cand_attrs_nxt[d] = '0;
      end
    end
  end

  // cell row
  assign chain[0] = '0;

  genvar gi;
  generate
    for (gi = 0; gi < ssw_pkg::CAPACITY; gi++) begin : g_cell
      ssw_cell u_cell (
        .clk       (clk),
        .rst_n     (rst_n),
        .bcast     (bcast),
        .chain_in  (chain[gi]),
        .chain_out (chain[gi+1]),
        .st        (cst[gi])
      );
      assign dom_vec[gi]  = cst[gi].dom_by;
      assign kill_vec[gi] = cst[gi].kill;
      assign pend_vec[gi] = cst[gi].pend;
      assign sel_vec[gi]  = cst[gi].sel;
    end
  endgenerate

  always_comb begin
    rd_id = '0;
    for (int i = 0; i < ssw_pkg::CAPACITY; i++) begin
      rd_id = rd_id | cst[i].id_sel;
    end
  end

  assign any_dom   = |dom_vec;
  assign any_free  = chain[ssw_pkg::CAPACITY].seen_free;
  assign any_pend  = chain[ssw_pkg::CAPACITY].seen_pend;
  assign do_insert = pass_r && !any_dom;

  always_comb begin
    bcast.attrs   = cand_attrs_r;
    bcast.mask    = ssw_pkg::DIMS'(sub_mask_r);
    bcast.ident   = cand_id_r;
    bcast.apply   = (state_r == ST_DEC) && out_free && do_insert;
    bcast.rd_load = accept && in_ch.mode;
    bcast.rd_step = (state_r == ST_RD) && out_free;
  end

  // control and result selection
  always_comb begin
    state_nxt       = state_r;
    emit            = 1'b0;
    out_status_nxt  = ssw_pkg::STAT_INS;
    out_removed_nxt = '0;
    out_id_nxt      = '0;
    out_ev_nxt      = 1'b0;
    out_last_nxt    = 1'b1;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          state_nxt = in_ch.mode ? ST_RD : ST_CMP;
        end
      end
      ST_CMP: begin
        state_nxt = ST_DEC;
      end
      ST_DEC: begin
        if (out_free) begin
          emit      = 1'b1;
          state_nxt = ST_IDLE;
          if (!pass_r) begin
            out_status_nxt = ssw_pkg::STAT_FILT;
          end else if (any_dom) begin
            out_status_nxt = ssw_pkg::STAT_DOM;
          end else begin
            out_status_nxt  = any_free ? ssw_pkg::STAT_INS : ssw_pkg::STAT_FULL;
            out_removed_nxt = ssw_pkg::REM_W'($countones(kill_vec));
          end
        end
      end
      ST_RD: begin
        if (out_free) begin
          emit = 1'b1;
          if (any_pend) begin
            out_id_nxt   = rd_id;
            out_ev_nxt   = 1'b1;
            out_last_nxt = !(|(pend_vec & ~sel_vec));
          end
          if (out_last_nxt) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      sub_mask_r  <= '1;
      kw_mask_r   <= '0;
      dist_lim_r  <= '1;
      pass_r      <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_we) begin
        case (cfg_idx)
          ssw_pkg::REG_SUBSPACE: sub_mask_r <= cfg_wdata[ssw_pkg::MASK_W-1:0];
          ssw_pkg::REG_KEYWORD:  kw_mask_r  <= cfg_wdata[ssw_pkg::KW_W-1:0];
          ssw_pkg::REG_DIST:     dist_lim_r <= cfg_wdata[ssw_pkg::DIST_W-1:0];
          default: ;
        endcase
      end
      if (accept) begin
        pass_r <= ((in_ch.poi_keywords & kw_mask_r) == kw_mask_r) &&
                  (in_ch.distance <= dist_lim_r);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cand_attrs_r <= cand_attrs_nxt;
      cand_id_r    <= in_ch.poi_id;
    end
    if (emit) begin
      out_status_r  <= out_status_nxt;
      out_removed_r <= out_removed_nxt;
      out_id_r      <= out_id_nxt;
      out_ev_r      <= out_ev_nxt;
      out_last_r    <= out_last_nxt;
    end
  end

  a_sel_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(sel_vec))
    else $error("more than one cell selected for readout");

  a_offer_to_cmp: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && !in_ch.mode) |=> (state_r == ST_CMP))
    else $error("offer did not enter compare");

  a_full_no_removal: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_status_r == ssw_pkg::STAT_FULL) |-> (out_removed_r == '0))
    else $error("window full reported with removals");

  a_entry_status: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_ev_r) |-> (out_status_r == ssw_pkg::STAT_INS && out_removed_r == '0))
    else $error("readout transaction with offer status");

endmodule
